FILE: src/fractal_escape_time_core_macros.svh
// Assertion macros shared by the escape-time checker.
`ifndef FRACTAL_ESCAPE_TIME_CORE_MACROS_SVH
`define FRACTAL_ESCAPE_TIME_CORE_MACROS_SVH

// Same-cycle implication, ignored while reset is high.
`define FET_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, ignored while reset is high.
`define FET_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that also holds across reset.
`define FET_ASSERT_ALWAYS(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

FILE: src/fet_pkg.sv
// Types and constants for the escape-time core.
package fet_pkg;

  localparam int PT_W   = 32;  // point and constant width
  localparam int Z_W    = 33;  // z component, magnitude below 2^32
  localparam int PROD_W = 66;  // exact product of two z components
  localparam int WIDE_W = 67;  // doubled cross term and z before range check
  localparam int CNT_W  = 9;
  localparam int IDX_W  = 3;

  typedef logic signed [PT_W-1:0]   point_t;
  typedef logic signed [Z_W-1:0]    z_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [WIDE_W-1:0] wide_t;
  typedef logic [CNT_W-1:0]         count_t;

  localparam logic [1:0] KIND_MANDELBROT = 2'd0;
  localparam logic [1:0] KIND_JULIA      = 2'd1;

  localparam logic [IDX_W-1:0] REG_KIND   = 3'd0;
  localparam logic [IDX_W-1:0] REG_LIMIT  = 3'd1;
  localparam logic [IDX_W-1:0] REG_RADIUS = 3'd2;
  localparam logic [IDX_W-1:0] REG_JREAL  = 3'd3;
  localparam logic [IDX_W-1:0] REG_JIMAG  = 3'd4;

  localparam count_t LIMIT_RESET = 9'd100;

  // largest z magnitude that can still lie inside any radius
  localparam wide_t Z_MAX = 67'sd4294967295;

  // per-point control that rides along the pipeline
  typedef struct packed {
    logic   valid;
    logic   done;
    logic   invalid;
    count_t count;
    point_t cr;
    point_t ci;
  } ctl_t;

endpackage

FILE: src/fractal_escape_time_core.sv
// A point passes an entry register, then MAX_ITERATIONS unrolled iterations, to the result.
// Throughput: one point per cycle while the result is not stalled; one unrolled iteration
// is three register stages (multiply, escape test and shift, add of c).
// A stalled result freezes the whole pipeline; point_stall follows it.
// Reset clears all stage valid bits and loads the register defaults.
// Register writes take effect at once; cfg_ready is always high.
module fractal_escape_time_core #(
  parameter int MAX_ITERATIONS = 256,
  parameter int FRACTION_BITS  = 28
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     point_valid,
  output logic                     point_stall,
  input  fet_pkg::point_t          point_real,
  input  fet_pkg::point_t          point_imag,
  output logic                     result_valid,
  input  logic                     result_stall,
  output fet_pkg::count_t          iteration_count,
  output logic                     kind_invalid,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [fet_pkg::IDX_W-1:0] cfg_index,
  input  logic [31:0]              cfg_data
);

  // configuration registers
  logic [1:0]      fractal_kind;
  fet_pkg::count_t iteration_limit;
  logic [31:0]     escape_radius;
  fet_pkg::point_t julia_real;
  fet_pkg::point_t julia_imag;
  logic [63:0]     radius_sq;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      fractal_kind    <= fet_pkg::KIND_MANDELBROT;
      iteration_limit <= fet_pkg::LIMIT_RESET;
      escape_radius   <= 32'(64'd2 << FRACTION_BITS);
      julia_real      <= '0;
      julia_imag      <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        fet_pkg::REG_KIND:   fractal_kind    <= cfg_data[1:0];
        fet_pkg::REG_LIMIT:  iteration_limit <= cfg_data[fet_pkg::CNT_W-1:0];
        fet_pkg::REG_RADIUS: escape_radius   <= cfg_data;
        fet_pkg::REG_JREAL:  julia_real      <= fet_pkg::point_t'(cfg_data);
        fet_pkg::REG_JIMAG:  julia_imag      <= fet_pkg::point_t'(cfg_data);
        default: ;
      endcase
    end
  end

  // squared radius is registered from escape_radius, so it lags a radius write
  always_ff @(posedge clk) begin
    radius_sq <= 64'(escape_radius) * 64'(escape_radius);
  end

  // pipeline storage; ctl_z[k] and z regs feed iteration k, ctl_z[MAX] is the result
  fet_pkg::ctl_t  ctl_z [MAX_ITERATIONS+1];
  fet_pkg::z_t    zr_q  [MAX_ITERATIONS];
  fet_pkg::z_t    zi_q  [MAX_ITERATIONS];
  logic           zbig_q[MAX_ITERATIONS];
  fet_pkg::ctl_t  ctl_p [MAX_ITERATIONS];
  fet_pkg::prod_t sqr_q [MAX_ITERATIONS];
  fet_pkg::prod_t sqi_q [MAX_ITERATIONS];
  fet_pkg::prod_t crs_q [MAX_ITERATIONS];
  logic           big_p [MAX_ITERATIONS];
  fet_pkg::ctl_t  ctl_d [MAX_ITERATIONS];
  fet_pkg::wide_t dr_q  [MAX_ITERATIONS];
  fet_pkg::wide_t di_q  [MAX_ITERATIONS];

  logic advance;
  assign advance     = !ctl_z[MAX_ITERATIONS].valid || !result_stall;
  assign point_stall = !advance;

  // entry: pick start z and c from the kind
  fet_pkg::ctl_t ent_ctl;
  fet_pkg::z_t   ent_zr;
  fet_pkg::z_t   ent_zi;

  always_comb begin
    ent_ctl.valid   = point_valid;
    ent_ctl.done    = 1'b0;
    ent_ctl.invalid = 1'b0;
    ent_ctl.count   = '0;
    ent_ctl.cr      = point_real;
    ent_ctl.ci      = point_imag;
    ent_zr          = '0;
    ent_zi          = '0;
    unique case (fractal_kind)
      fet_pkg::KIND_MANDELBROT: ;
      fet_pkg::KIND_JULIA: begin
        ent_zr     = {point_real[fet_pkg::PT_W-1], point_real};
        ent_zi     = {point_imag[fet_pkg::PT_W-1], point_imag};
        ent_ctl.cr = julia_real;
        ent_ctl.ci = julia_imag;
      end
      default: begin
        ent_ctl.invalid = 1'b1;
        ent_ctl.done    = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_z[0].valid <= 1'b0;
    end else if (advance) begin
      ctl_z[0]  <= ent_ctl;
      zr_q[0]   <= ent_zr;
      zi_q[0]   <= ent_zi;
      zbig_q[0] <= 1'b0;
    end
  end

  for (genvar k = 0; k < MAX_ITERATIONS; k++) begin : g_iter
    fet_pkg::ctl_t  test_ctl;
    logic [65:0]    mag_sum;
    logic           in_radius;
    logic           limit_hit;
    fet_pkg::wide_t diff;
    fet_pkg::wide_t cross2;

    // stage 1: exact squares and cross product
    always_ff @(posedge clk) begin
      if (rst) begin
        ctl_p[k].valid <= 1'b0;
      end else if (advance) begin
        ctl_p[k] <= ctl_z[k];
        sqr_q[k] <= zr_q[k] * zr_q[k];
        sqi_q[k] <= zi_q[k] * zi_q[k];
        crs_q[k] <= zr_q[k] * zi_q[k];
        big_p[k] <= zbig_q[k];
      end
    end

    // stage 2: escape test, then floor shift of both new terms
    always_comb begin
      mag_sum   = 66'(sqr_q[k][64:0]) + 66'(sqi_q[k][64:0]);
      in_radius = !big_p[k] && (mag_sum <= {2'b00, radius_sq});
      limit_hit = (32'(k) >= 32'(iteration_limit));
      test_ctl  = ctl_p[k];
      if (!ctl_p[k].done) begin
        if (limit_hit) begin
          test_ctl.done = 1'b1;
        end else if (!in_radius) begin
          test_ctl.done  = 1'b1;
          test_ctl.count = fet_pkg::count_t'(k);
        end
      end
      diff   = fet_pkg::wide_t'(sqr_q[k]) - fet_pkg::wide_t'(sqi_q[k]);
      cross2 = fet_pkg::wide_t'(crs_q[k]) <<< 1;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        ctl_d[k].valid <= 1'b0;
      end else if (advance) begin
        ctl_d[k] <= test_ctl;
        dr_q[k]  <= diff >>> FRACTION_BITS;
        di_q[k]  <= cross2 >>> FRACTION_BITS;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        ctl_z[k+1].valid <= 1'b0;
      end else if (advance) begin
        ctl_z[k+1] <= ctl_d[k];
      end
    end

    if (k < MAX_ITERATIONS - 1) begin : g_next_z
      fet_pkg::wide_t nr;
      fet_pkg::wide_t ni;

      // stage 3: add c; z outside 2^32 is flagged and counts as escaped
      always_comb begin
        nr = dr_q[k] + fet_pkg::wide_t'(ctl_d[k].cr);
        ni = di_q[k] + fet_pkg::wide_t'(ctl_d[k].ci);
      end

      always_ff @(posedge clk) begin
        if (advance) begin
          zr_q[k+1]   <= nr[fet_pkg::Z_W-1:0];
          zi_q[k+1]   <= ni[fet_pkg::Z_W-1:0];
          zbig_q[k+1] <= (nr > fet_pkg::Z_MAX) || (nr < -fet_pkg::Z_MAX) ||
                         (ni > fet_pkg::Z_MAX) || (ni < -fet_pkg::Z_MAX);
        end
      end
    end
  end

  assign result_valid    = ctl_z[MAX_ITERATIONS].valid;
  assign iteration_count = ctl_z[MAX_ITERATIONS].count;
  assign kind_invalid    = ctl_z[MAX_ITERATIONS].invalid;

endmodule

FILE: src/fet_checker.sv
// Port-level checks for the escape-time core and the bind that attaches them.
`include "fractal_escape_time_core_macros.svh"

module fet_checker (
  input logic                     clk,
  input logic                     rst,
  input logic                     point_valid,
  input logic                     point_stall,
  input logic                     result_valid,
  input logic                     result_stall,
  input logic [fet_pkg::CNT_W-1:0] iteration_count,
  input logic                     kind_invalid
);

  `FET_ASSERT_NEXT(a_result_hold, result_valid && result_stall, result_valid && $stable(iteration_count) && $stable(kind_invalid), "stalled result changed")
  `FET_ASSERT_NOW(a_invalid_zero, result_valid && kind_invalid, iteration_count == '0, "invalid kind with nonzero count")
  `FET_ASSERT_NOW(a_stall_source, point_stall, result_valid && result_stall, "input stalled without a stalled result")
  `FET_ASSERT_ALWAYS(a_reset_empty, rst, !result_valid, "result valid right after reset")

endmodule

bind fractal_escape_time_core fet_checker u_fet_checker (.*);
